// ----- rtl/day_of_year_to_calendar_date_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the day-of-year to calendar date converter
// Immediate-implication and next-cycle-implication checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef DAY_OF_YEAR_TO_CALENDAR_DATE_ASSERT_SVH
`define DAY_OF_YEAR_TO_CALENDAR_DATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DOYCAL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DOYCAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/doycal_pkg.sv -----
// ----------------------------------------------------------------------------
// doycal_pkg
// Shared types, constants and calendar tables for the date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package doycal_pkg;

	// Largest reference year that is accepted.
	localparam logic [13:0] YEAR_MAX = 14'd10000;

	// Year lengths.
	localparam logic [8:0] YEAR_LEN_NORMAL = 9'd365;
	localparam logic [8:0] YEAR_LEN_LEAP   = 9'd366;

	// Month codes used by the month walk.
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// Day of month reported with an error.
	localparam logic [4:0] DAY_ERROR = 5'd1;

	// Days in each month of a normal year, January first.
	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DOWN,
		ST_UP,
		ST_MONTH,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic check;
		logic step_dn;
		logic step_up;
		logic step_mo;
		logic capture;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic err;
		logic need_dn;
		logic need_up;
		logic need_mo;
	} status_t;

	// A year is a leap year when its two low bits are zero.
	function automatic logic is_leap(input logic signed [14:0] year);
		return (year[1:0] == 2'b00);
	endfunction

	function automatic logic [8:0] year_len(input logic signed [14:0] year);
		return is_leap(year) ? YEAR_LEN_LEAP : YEAR_LEN_NORMAL;
	endfunction

	// Days in a month; months past December read as December.
	function automatic logic [4:0] month_len_of(input logic [3:0] month,
			input logic signed [14:0] year);
		logic [3:0] idx;
		idx = (month > MONTH_DEC) ? 4'd11 : (month - 4'd1);
		if (month == MONTH_FEB && is_leap(year))
			return FEB_LEAP_LEN;
		return MONTH_LEN[idx];
	endfunction

endpackage

// ----- rtl/doycal_ctrl.sv -----
// ----------------------------------------------------------------------------
// doycal_ctrl
// Controller: sequences the range check, year walk, month walk and hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module doycal_ctrl
	import doycal_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_nxt = status.err ? ST_FINISH : ST_DOWN;
			end
			ST_DOWN: begin
				if (status.need_dn)
					cmd.step_dn = 1'b1;
				else
					state_nxt = ST_UP;
			end
			ST_UP: begin
				if (status.need_up)
					cmd.step_up = 1'b1;
				else
					state_nxt = ST_MONTH;
			end
			ST_MONTH: begin
				if (status.need_mo)
					cmd.step_mo = 1'b1;
				else
					state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// The output register holds an item until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/doycal_dp.sv -----
// ----------------------------------------------------------------------------
// doycal_dp
// Datapath: working registers for the day, year and month walk, and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module doycal_dp
	import doycal_pkg::*;
(
	input  logic               clk,
	input  logic signed [15:0] day_of_year,
	input  logic        [13:0] ref_year,
	input  logic               adjust_year,
	input  cmd_t               cmd,
	output status_t            status,
	output logic signed [14:0] out_year,
	output logic        [3:0]  out_month,
	output logic        [4:0]  out_day,
	output logic               ok
);

	logic signed [16:0] doy_q;
	logic signed [14:0] year_q;
	logic        [3:0]  month_q;
	logic        [8:0]  end_q;
	logic               adjust_q;
	logic               good_q;

	logic signed [14:0] out_year_q;
	logic        [3:0]  out_month_q;
	logic        [4:0]  out_day_q;
	logic               ok_q;

	logic signed [14:0] year_prev;
	logic signed [14:0] year_next;
	logic        [8:0]  len_cur;
	logic        [8:0]  len_prev;
	logic        [3:0]  month_next;
	logic        [4:0]  dim_next;
	logic        [4:0]  dim_cur;
	logic        [9:0]  mday_full;
	logic               doy_low;
	logic               doy_high;

	// Neighbor years and lengths used by the year walk.
	assign year_prev  = year_q - 15'sd1;
	assign year_next  = year_q + 15'sd1;
	assign len_cur    = year_len(year_q);
	assign len_prev   = year_len(year_prev);
	assign month_next = month_q + 4'd1;
	assign dim_next   = month_len_of(month_next, year_q);
	assign dim_cur    = month_len_of(month_q, year_q);

	// Position of the day against the current year.
	assign doy_low  = (doy_q < 17'sd1);
	assign doy_high = (doy_q > $signed({8'b0, len_cur}));

	// Status for the controller.
	always_comb begin
		status.err     = (year_q > $signed({1'b0, YEAR_MAX})) ||
			(!adjust_q && (doy_low || doy_high));
		status.need_dn = doy_low;
		status.need_up = doy_high;
		status.need_mo = ($signed({8'b0, end_q}) < doy_q) && (month_q < MONTH_DEC);
	end

	// Day of month once the month walk has stopped.
	assign mday_full = doy_q[9:0] - {1'b0, end_q} + {5'b0, dim_cur};

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			doy_q    <= 17'(day_of_year);
			year_q   <= $signed({1'b0, ref_year});
			month_q  <= MONTH_JAN;
			end_q    <= {4'b0, MONTH_LEN[0]};
			adjust_q <= adjust_year;
		end
		if (cmd.check) begin
			good_q <= !status.err;
		end
		if (cmd.step_dn) begin
			year_q <= year_prev;
			doy_q  <= doy_q + $signed({8'b0, len_prev});
		end
		if (cmd.step_up) begin
			year_q <= year_next;
			doy_q  <= doy_q - $signed({8'b0, len_cur});
		end
		if (cmd.step_mo) begin
			month_q <= month_next;
			end_q   <= end_q + {4'b0, dim_next};
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			out_year_q  <= year_q;
			out_month_q <= month_q;
			out_day_q   <= good_q ? mday_full[4:0] : DAY_ERROR;
			ok_q        <= good_q;
		end
	end

	assign out_year  = out_year_q;
	assign out_month = out_month_q;
	assign out_day   = out_day_q;
	assign ok        = ok_q;

endmodule

// ----- rtl/day_of_year_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// day_of_year_to_calendar_date
// Converts a signed day number within a reference year to year, month and
// day of month, with optional carry into neighboring years.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   input    in_valid/in_ready    day_of_year, ref_year, adjust_year
//   output   out_valid/out_ready  out_year, out_month, out_day, ok
//
// An item goes from acceptance through the range check, the year walk and the
// month walk to the output register; the year walk covers at most about 90
// years and the month walk at most 11 months, one year or one month per cycle.
// An item that fails the range check skips both walks to the final hand-off.
// A new item is accepted while the previous result waits in the output
// register; a stalled output only holds the block in its final hand-off step.
// Reset clears the controller and the output valid flag only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module day_of_year_to_calendar_date
	import doycal_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] day_of_year,
	input  logic        [13:0] ref_year,
	input  logic               adjust_year,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] out_year,
	output logic        [3:0]  out_month,
	output logic        [4:0]  out_day,
	output logic               ok
);

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	doycal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and registers.
	doycal_dp u_dp (
		.clk         (clk),
		.day_of_year (day_of_year),
		.ref_year    (ref_year),
		.adjust_year (adjust_year),
		.cmd         (cmd),
		.status      (status),
		.out_year    (out_year),
		.out_month   (out_month),
		.out_day     (out_day),
		.ok          (ok)
	);

	// Checks on the delivered results and on the busy window.
`include "day_of_year_to_calendar_date_assert.svh"

	`DOYCAL_ASSERT_NOW(a_month_range, out_valid, (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC), "month out of range")
	`DOYCAL_ASSERT_NOW(a_error_date, out_valid && !ok, (out_month == MONTH_JAN) && (out_day == DAY_ERROR), "error item without month 1 day 1")
	`DOYCAL_ASSERT_NOW(a_day_range, out_valid && ok, out_day != 5'd0, "day of month is zero")
	`DOYCAL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second item accepted while busy")

endmodule
